[rtl/charge_hysteresis_limiter_macros.svh]
// Assertion macros used by the checker file of the charge hysteresis limiter.
`ifndef CHARGE_HYSTERESIS_LIMITER_MACROS_SVH
`define CHARGE_HYSTERESIS_LIMITER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CHL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/chl_pkg.sv]
// Types, constants and control store of the charge hysteresis limiter.
`timescale 1ns / 1ps

package chl_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MODE_W     = 2;
    localparam int RATE_W     = 25;
    localparam int GAIN_W     = 32;
    localparam int CHARGE_W   = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TDATA_W    = 2 * SAMPLE_W;

    // datapath widths
    localparam int A_W = 27;
    localparam int B_W = GAIN_W + 1;
    localparam int P_W = A_W + B_W;
    localparam int R_W = P_W - 16;
    localparam int G_W = 26;
    localparam int O_W = 26;
    localparam int H_W = A_W;
    localparam int T_W = 28;
    localparam int V_W = 30;

    localparam logic [CHARGE_W-1:0] CHARGE_ONE = 25'h100_0000;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 24'sh80_0000;

    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIMPLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECHARGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP   = 2'd3;

    localparam logic [MODE_W-1:0]   MODE_RST     = MODE_SINGLE;
    localparam logic [RATE_W-1:0]   DRAIN_RST    = 25'd1398101;
    localparam logic [RATE_W-1:0]   RECHARGE_RST = 25'd7862;
    localparam logic [GAIN_W-1:0]   MAKEUP_RST   = 32'd11654129;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HALF   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SIMPLE = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_HEAD_C,
        OP_HEAD_T,
        OP_GAIN,
        OP_OUT,
        OP_UPD,
        OP_ABS,
        OP_C1,
        OP_RECH,
        OP_SAT
    } chl_op_t;

    typedef enum logic [1:0] {
        SH_16,
        SH_23,
        SH_24,
        SH_25
    } chl_sh_t;

    typedef enum logic [1:0] {
        A_H,
        A_X,
        A_O,
        A_M
    } chl_asel_t;

    typedef enum logic [2:0] {
        B_RR,
        B_G,
        B_C,
        B_DRAIN,
        B_GAIN
    } chl_bsel_t;

    typedef enum logic [1:0] {
        J_NONE,
        J_SIMPLE,
        J_PAIR_MORE
    } chl_jmp_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DONE
    } chl_seq_t;

    typedef struct packed {
        chl_op_t           op;
        chl_sh_t           sh;
        logic              mul_en;
        chl_asel_t         asel;
        chl_bsel_t         bsel;
        chl_jmp_t          jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } chl_uword_t;

    typedef struct packed {
        logic      start;
        logic      half;
        chl_op_t   op;
        chl_sh_t   sh;
        logic      mul_en;
        chl_asel_t asel;
        chl_bsel_t bsel;
    } chl_ctrl_t;

    typedef struct packed {
        logic [RATE_W-1:0] drain;
        logic [RATE_W-1:0] recharge;
        logic [GAIN_W-1:0] makeup;
    } chl_cfg_t;

    function automatic chl_uword_t mk(
        input chl_op_t           op,
        input chl_sh_t           sh,
        input logic              mul_en,
        input chl_asel_t         asel,
        input chl_bsel_t         bsel,
        input chl_jmp_t          jmp,
        input logic [STEP_W-1:0] target,
        input logic              last
    );
        chl_uword_t w;
        w.op     = op;
        w.sh     = sh;
        w.mul_en = mul_en;
        w.asel   = asel;
        w.bsel   = bsel;
        w.jmp    = jmp;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // half update at 0..7, simple bipolar update at 8..15
    function automatic chl_uword_t ucode(input logic [STEP_W-1:0] step);
        chl_uword_t w;
        case (step)
            4'd0:    w = mk(OP_HEAD_C, SH_16, 1'b0, A_H, B_RR,    J_SIMPLE,    STEP_SIMPLE, 1'b0);
            4'd1:    w = mk(OP_NOP,    SH_16, 1'b1, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b0);
            4'd2:    w = mk(OP_GAIN,   SH_25, 1'b0, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b0);
            4'd3:    w = mk(OP_NOP,    SH_16, 1'b1, A_X, B_G,     J_NONE,      STEP_HALF,   1'b0);
            4'd4:    w = mk(OP_OUT,    SH_24, 1'b0, A_X, B_G,     J_NONE,      STEP_HALF,   1'b0);
            4'd5:    w = mk(OP_NOP,    SH_16, 1'b1, A_O, B_DRAIN, J_NONE,      STEP_HALF,   1'b0);
            4'd6:    w = mk(OP_UPD,    SH_23, 1'b1, A_O, B_GAIN,  J_NONE,      STEP_HALF,   1'b0);
            4'd7:    w = mk(OP_SAT,    SH_16, 1'b0, A_O, B_GAIN,  J_PAIR_MORE, STEP_HALF,   1'b1);
            4'd8:    w = mk(OP_NOP,    SH_16, 1'b1, A_X, B_C,     J_NONE,      STEP_HALF,   1'b0);
            4'd9:    w = mk(OP_OUT,    SH_24, 1'b0, A_X, B_C,     J_NONE,      STEP_HALF,   1'b0);
            4'd10:   w = mk(OP_ABS,    SH_16, 1'b1, A_O, B_GAIN,  J_NONE,      STEP_HALF,   1'b0);
            4'd11:   w = mk(OP_SAT,    SH_16, 1'b1, A_M, B_DRAIN, J_NONE,      STEP_HALF,   1'b0);
            4'd12:   w = mk(OP_C1,     SH_23, 1'b0, A_M, B_DRAIN, J_NONE,      STEP_HALF,   1'b0);
            4'd13:   w = mk(OP_HEAD_T, SH_16, 1'b0, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b0);
            4'd14:   w = mk(OP_NOP,    SH_16, 1'b1, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b0);
            4'd15:   w = mk(OP_RECH,   SH_24, 1'b0, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b1);
            default: w = mk(OP_NOP,    SH_16, 1'b0, A_H, B_RR,    J_NONE,      STEP_HALF,   1'b1);
        endcase
        return w;
    endfunction

endpackage

[rtl/charge_hysteresis_limiter.sv]
// Top level of the charge hysteresis limiter: handshakes, registers and sequencer.
//
//  channel  dir  handshake                fields
//  s_*      in   s_tvalid / s_tready      s_tdata: pos_sample, neg_sample
//  m_*      out  m_tvalid / m_tready      m_tdata: pos_out, neg_out
//  cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Sequencing: one shared 27x33 multiplier runs a 16-step microprogram; a word takes
// 8 steps single-sided, 9 simple, 16 in pair mode, then waits in the done state for
// the output load; a new word is taken only after that load.
// Reset: registers to defaults, charge zero, positive half first.
// Stalls: the result waits in the output register; a new word is taken meanwhile
// and the sequencer holds before its load until the old word has gone.
`timescale 1ns / 1ps

module charge_hysteresis_limiter import chl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // pos_sample, neg_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // pos_out, neg_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MODE_W-1:0]   mode_reg;
    logic [RATE_W-1:0]   drain_reg;
    logic [RATE_W-1:0]   recharge_reg;
    logic [GAIN_W-1:0]   makeup_reg;

    chl_seq_t            state_reg;
    chl_seq_t            state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                flip_reg;
    logic                half_reg;
    logic                second_reg;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_pos_reg;
    logic signed [SAMPLE_W-1:0] out_neg_reg;

    chl_uword_t          word;
    chl_ctrl_t           ctrl;
    chl_cfg_t            cfg;
    logic                jump_taken;
    logic                accept;
    logic                out_free;
    logic                run;
    logic                load_out;
    logic signed [SAMPLE_W-1:0] pos_res;
    logic signed [SAMPLE_W-1:0] neg_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RST;
            drain_reg    <= DRAIN_RST;
            recharge_reg <= RECHARGE_RST;
            makeup_reg   <= MAKEUP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                REG_DRAIN:    drain_reg    <= cfg_data[RATE_W-1:0];
                REG_RECHARGE: recharge_reg <= cfg_data[RATE_W-1:0];
                REG_MAKEUP:   makeup_reg   <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign word     = ucode(step_reg);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        case (word.jmp)
            J_SIMPLE:    jump_taken = mode_reg inside {MODE_SIMPLE, MODE_SPARE};
            J_PAIR_MORE: jump_taken = (mode_reg == MODE_PAIR) && !second_reg;
            default:     jump_taken = 1'b0;
        endcase
    end

    // next state and step
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                step_next = STEP_HALF;
                if (accept)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (jump_taken)
                begin
                    step_next = word.target;
                end
                else if (word.last)
                begin
                    state_next = SEQ_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        run      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            SEQ_IDLE: s_tready = 1'b1;
            SEQ_RUN:  run      = 1'b1;
            SEQ_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            step_reg   <= STEP_HALF;
            flip_reg   <= 1'b0;
            half_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
            begin
                half_reg   <= (mode_reg == MODE_PAIR) && flip_reg;
                second_reg <= 1'b0;
                if (mode_reg == MODE_PAIR)
                begin
                    flip_reg <= ~flip_reg;
                end
            end
            else if (run && jump_taken && (word.jmp == J_PAIR_MORE))
            begin
                half_reg   <= ~half_reg;
                second_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        ctrl.start  = accept;
        ctrl.half   = half_reg;
        ctrl.op     = run ? word.op : OP_NOP;
        ctrl.sh     = word.sh;
        ctrl.mul_en = run && word.mul_en;
        ctrl.asel   = word.asel;
        ctrl.bsel   = word.bsel;
    end

    assign cfg.drain    = drain_reg;
    assign cfg.recharge = recharge_reg;
    assign cfg.makeup   = makeup_reg;

    chl_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg),
        .pos_sample ($signed(s_tdata[SAMPLE_W-1:0])),
        .neg_sample ($signed(s_tdata[TDATA_W-1:SAMPLE_W])),
        .pos_res    (pos_res),
        .neg_res    (neg_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pos_reg <= pos_res;
            out_neg_reg <= neg_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_neg_reg, out_pos_reg};

endmodule

[rtl/chl_datapath.sv]
// Shared multiplier, rounding and charge arithmetic driven by the control word.
`timescale 1ns / 1ps

module chl_datapath import chl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  chl_ctrl_t                  ctrl,
    input  chl_cfg_t                   cfg,
    input  logic signed [SAMPLE_W-1:0] pos_sample,
    input  logic signed [SAMPLE_W-1:0] neg_sample,
    output logic signed [SAMPLE_W-1:0] pos_res,
    output logic signed [SAMPLE_W-1:0] neg_res
);

    logic [CHARGE_W-1:0]        charge_reg;
    logic signed [SAMPLE_W-1:0] x_pos_reg;
    logic signed [SAMPLE_W-1:0] x_neg_reg;
    logic signed [P_W-1:0]      prod_reg;
    logic signed [H_W-1:0]      h_reg;
    logic [G_W-1:0]             g_reg;
    logic signed [O_W-1:0]      o_reg;
    logic signed [O_W-1:0]      m_reg;
    logic signed [T_W-1:0]      t_reg;
    logic signed [SAMPLE_W-1:0] pos_res_reg;
    logic signed [SAMPLE_W-1:0] neg_res_reg;

    logic signed [SAMPLE_W-1:0] x_sel;
    logic signed [A_W-1:0]      mul_a;
    logic signed [B_W-1:0]      mul_b;
    logic signed [P_W-1:0]      prod;
    logic signed [R_W-1:0]      rnd_q;
    logic                       rnd_b;
    logic signed [R_W-1:0]      rnd;
    logic signed [V_W-1:0]      rnd_v;
    logic signed [V_W-1:0]      g_v;
    logic signed [V_W-1:0]      c_v;
    logic signed [V_W-1:0]      upd_sum;
    logic signed [V_W-1:0]      gain_sum;
    logic signed [V_W-1:0]      c1_sum;
    logic signed [V_W-1:0]      rech_sum;
    logic signed [T_W-1:0]      head_src;
    logic signed [T_W-1:0]      head_full;
    logic signed [O_W-1:0]      abs_o;
    logic signed [SAMPLE_W-1:0] sat_val;

    function automatic logic [CHARGE_W-1:0] clamp_charge(input logic signed [V_W-1:0] v);
        logic [CHARGE_W-1:0] c;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > $signed(V_W'(CHARGE_ONE)))
        begin
            c = CHARGE_ONE;
        end
        else
        begin
            c = v[CHARGE_W-1:0];
        end
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [R_W-1:0] r);
        logic signed [SAMPLE_W-1:0] s;
        if (r > R_W'(OUT_MAX))
        begin
            s = OUT_MAX;
        end
        else if (r < R_W'(OUT_MIN))
        begin
            s = OUT_MIN;
        end
        else
        begin
            s = $signed(r[SAMPLE_W-1:0]);
        end
        return s;
    endfunction

    assign x_sel = ctrl.half ? x_neg_reg : x_pos_reg;

    always_comb
    begin
        case (ctrl.asel)
            A_H:     mul_a = h_reg;
            A_X:     mul_a = A_W'(x_sel);
            A_O:     mul_a = A_W'(o_reg);
            A_M:     mul_a = A_W'(m_reg);
            default: mul_a = h_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.bsel)
            B_RR:    mul_b = $signed(B_W'(cfg.recharge));
            B_G:     mul_b = $signed(B_W'(g_reg));
            B_C:     mul_b = $signed(B_W'(charge_reg));
            B_DRAIN: mul_b = $signed(B_W'(cfg.drain));
            B_GAIN:  mul_b = $signed(B_W'(cfg.makeup));
            default: mul_b = $signed(B_W'(cfg.recharge));
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half up: floor shift plus the bit just below the cut
    always_comb
    begin
        case (ctrl.sh)
            SH_16:
            begin
                rnd_q = R_W'(prod_reg >>> 16);
                rnd_b = prod_reg[15];
            end
            SH_23:
            begin
                rnd_q = R_W'(prod_reg >>> 23);
                rnd_b = prod_reg[22];
            end
            SH_24:
            begin
                rnd_q = R_W'(prod_reg >>> 24);
                rnd_b = prod_reg[23];
            end
            SH_25:
            begin
                rnd_q = R_W'(prod_reg >>> 25);
                rnd_b = prod_reg[24];
            end
            default:
            begin
                rnd_q = R_W'(prod_reg >>> 16);
                rnd_b = prod_reg[15];
            end
        endcase
    end

    assign rnd      = rnd_q + $signed({{(R_W-1){1'b0}}, rnd_b});
    assign rnd_v    = $signed(rnd[V_W-1:0]);
    assign g_v      = $signed(V_W'(g_reg));
    assign c_v      = $signed(V_W'(charge_reg));
    // negative half adds its (negative) output term, which drains the charge as on the positive half
    assign upd_sum  = ctrl.half ? g_v + rnd_v : g_v - rnd_v;
    assign gain_sum = c_v + rnd_v;
    assign c1_sum   = c_v - rnd_v;
    assign rech_sum = V_W'(t_reg) + rnd_v;
    assign head_src = (ctrl.op == OP_HEAD_T) ? t_reg : $signed(T_W'(charge_reg));
    assign head_full = $signed(T_W'(CHARGE_ONE)) - head_src;
    assign abs_o    = o_reg[O_W-1] ? -o_reg : o_reg;
    assign sat_val  = sat_out(rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_reg <= '0;
        end
        else
        begin
            case (ctrl.op)
                OP_UPD:  charge_reg <= clamp_charge(upd_sum);
                OP_RECH: charge_reg <= clamp_charge(rech_sum);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_pos_reg   <= pos_sample;
            x_neg_reg   <= neg_sample;
            neg_res_reg <= '0;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod;
        end
        case (ctrl.op)
            OP_HEAD_C, OP_HEAD_T: h_reg <= $signed(head_full[H_W-1:0]);
            OP_GAIN:              g_reg <= gain_sum[G_W-1:0];
            OP_OUT:               o_reg <= $signed(rnd[O_W-1:0]);
            OP_ABS:               m_reg <= abs_o;
            OP_C1:                t_reg <= $signed(c1_sum[T_W-1:0]);
            OP_SAT:
            begin
                if (ctrl.half)
                begin
                    neg_res_reg <= sat_val;
                end
                else
                begin
                    pos_res_reg <= sat_val;
                end
            end
            default: ;
        endcase
    end

    assign pos_res = pos_res_reg;
    assign neg_res = neg_res_reg;

endmodule

[rtl/chl_checker.sv]
// Port-level checks of the charge hysteresis limiter, bound to the top level.
`timescale 1ns / 1ps
`include "charge_hysteresis_limiter_macros.svh"

module chl_checker import chl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    `CHL_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")
    `CHL_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")
    `CHL_ASSERT_NXT(a_no_instant_result, clk, rst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result shown one cycle after input")
    `CHL_ASSERT_IMP(a_ready_after_result, clk, rst_n, $rose(s_tready), m_tvalid, "input ready returned without a result")

endmodule

bind charge_hysteresis_limiter chl_checker u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
